@@ sv/aes_pkg.sv @@
// Shared types, constants and GF(2^8) helpers for the AES block cipher.
package aes_pkg;

  localparam int unsigned NumRoundKeys = 15;
  localparam int unsigned RkIdxW = 4;
  localparam int unsigned WordIdxW = 6;
  localparam int unsigned AddrW = 6;

  typedef enum logic [2:0] {
    RegMode = 3'd0,
    RegKey0 = 3'd1,
    RegKey1 = 3'd2,
    RegKey2 = 3'd3,
    RegKey3 = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    Key128 = 2'd0,
    Key192 = 2'd1,
    Key256 = 2'd2
  } key_len_e;

  typedef enum logic [2:0] {
    StIdle,
    StExpand,
    StInit,
    StRound,
    StDone
  } ctrl_state_e;

  typedef struct packed {
    logic        operation;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } aes_out_t;

  // controller -> datapath
  typedef struct packed {
    logic                exp_start;
    logic                exp_step;
    logic                load;
    logic                round;
    logic                last;
    logic [RkIdxW-1:0]   rk_idx;
  } aes_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic exp_done;
  } aes_sts_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] p;
    r = '0;
    p = a;
    for (int n = 0; n < 8; n++) begin
      if (b[n]) r = r ^ p;
      p = xtime(p);
    end
    return r;
  endfunction

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

@@ sv/aes_ctrl.sv @@
// Sequencer: key expansion when the keys are stale, then one cipher round per cycle.
module aes_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              operation_i,
  input  logic              stale_i,
  input  logic [1:0]        mode_i,
  input  aes_pkg::aes_sts_t sts_i,
  output aes_pkg::aes_cmd_t cmd_o,
  output logic              busy_o,
  output logic              done_o
);
  import aes_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [RkIdxW-1:0] cnt_q, cnt_d;
  logic [RkIdxW-1:0] nr_q, nr_d;
  logic              dec_q, dec_d;
  logic [RkIdxW-1:0] nr_mode;

  always_comb begin
    case (mode_i)
      Key128:  nr_mode = RkIdxW'(10);
      Key192:  nr_mode = RkIdxW'(12);
      default: nr_mode = RkIdxW'(14);
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    nr_d    = nr_q;
    dec_d   = dec_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          dec_d   = operation_i;
          nr_d    = nr_mode;
          state_d = stale_i ? StExpand : StInit;
        end
      end
      StExpand: if (sts_i.exp_done) state_d = StInit;
      StInit: begin
        cnt_d   = RkIdxW'(1);
        state_d = StRound;
      end
      StRound: begin
        cnt_d = cnt_q + RkIdxW'(1);
        if (cnt_q == nr_q) state_d = StDone;
      end
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy_o = (state_q != StIdle);
    done_o = (state_q == StDone);
    case (state_q)
      StIdle:   cmd_o.exp_start = start_i && stale_i;
      StExpand: cmd_o.exp_step = 1'b1;
      StInit: begin
        cmd_o.load   = 1'b1;
        cmd_o.rk_idx = dec_q ? nr_q : '0;
      end
      StRound: begin
        cmd_o.round  = 1'b1;
        cmd_o.last   = (cnt_q == nr_q);
        cmd_o.rk_idx = dec_q ? (nr_q - cnt_q) : cnt_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      nr_q    <= RkIdxW'(10);
      dec_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      nr_q    <= nr_d;
      dec_q   <= dec_d;
    end
  end

  a_done_after_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDone |-> $past(state_q) == StRound) else $error("done without round");
  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRound |-> cnt_q <= nr_q && cnt_q != '0) else $error("round count out of range");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.exp_step, cmd_o.load, cmd_o.round})) else $error("overlapping commands");
endmodule

@@ sv/aes_datapath.sv @@
// Key expansion engine, round key memory and the one-round cipher datapath.
module aes_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aes_pkg::aes_cmd_t cmd_i,
  input  aes_pkg::aes_in_t  in_i,
  input  logic [1:0]        mode_i,
  input  logic [255:0]      key_i,
  output aes_pkg::aes_sts_t sts_o,
  output logic [127:0]      state_o
);
  import aes_pkg::*;

  // one 128-bit round key per entry, one 32-bit lane written per expansion cycle
  logic [127:0] rk_mem [NumRoundKeys];
  logic [127:0] rk_q;
  logic [31:0] win_q [8];
  logic [WordIdxW-1:0] widx_q;
  logic [3:0] nk_q;
  logic [2:0] pos_q;
  logic [7:0] rc_q;
  logic       exp_q;
  logic [WordIdxW-1:0] total;
  logic [31:0] t, nw;
  logic [127:0] st_q;

  assign total = (nk_q == 4'd4) ? WordIdxW'(44) : (nk_q == 4'd6) ? WordIdxW'(52)
               : WordIdxW'(60);

  always_comb begin
    t = win_q[nk_q[2:0] - 3'd1];
    if (pos_q == 3'd0) t = sub_word({t[23:0], t[31:24]}) ^ {rc_q, 24'h0};
    else if (nk_q == 4'd8 && pos_q == 3'd4) t = sub_word(t);
    nw = win_q[0] ^ t;
  end

  assign sts_o.exp_done = exp_q && (widx_q == total);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= 1'b0;
    end else if (cmd_i.exp_start) begin
      exp_q <= 1'b1;
    end else if (sts_o.exp_done) begin
      exp_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_start) begin
      case (mode_i)
        Key128:  nk_q <= 4'd4;
        Key192:  nk_q <= 4'd6;
        default: nk_q <= 4'd8;
      endcase
      for (int i = 0; i < 8; i++) win_q[i] <= key_i[255-32*i -: 32];
      widx_q <= '0;
      pos_q  <= '0;
      rc_q   <= 8'h01;
    end else if (cmd_i.exp_step && !sts_o.exp_done) begin
      if (widx_q < WordIdxW'(nk_q)) begin
        rk_mem[widx_q[WordIdxW-1:2]][32*(3-widx_q[1:0]) +: 32] <= win_q[widx_q[2:0]];
      end else begin
        rk_mem[widx_q[WordIdxW-1:2]][32*(3-widx_q[1:0]) +: 32] <= nw;
        for (int i = 0; i < 7; i++)
          win_q[i] <= (3'(i) == nk_q[2:0] - 3'd1) ? nw : win_q[i+1];
        if (nk_q == 4'd8) win_q[7] <= nw;
        if (pos_q == 3'd0) rc_q <= xtime(rc_q);
        pos_q <= (pos_q == 3'(nk_q - 4'd1)) ? 3'd0 : pos_q + 3'd1;
      end
      widx_q <= widx_q + WordIdxW'(1);
    end
  end

  // round key read: registered, so the index is issued the cycle before the key is used
  always_ff @(posedge clk_i) begin
    rk_q <= rk_mem[cmd_i.rk_idx];
  end

  // rk_q is registered: pipeline the op flags the same way so they meet the key
  logic load_q, round_q, last_q, dec_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= 1'b0;
      round_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      load_q <= cmd_i.load;
      round_q <= cmd_i.round;
      last_q <= cmd_i.last;
    end
  end

  logic [127:0] blk_q;

  logic [7:0] s [16];
  logic [7:0] sh [16];
  logic [7:0] sb [16];
  logic [7:0] ak [16];
  logic [7:0] mc [16];
  logic [127:0] nxt;

  always_comb begin
    for (int n = 0; n < 16; n++) s[n] = st_q[127-8*n -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        if (dec_q) sh[((c + r) % 4) * 4 + r] = s[c*4 + r];
        else sh[c*4 + r] = s[((c + r) % 4) * 4 + r];
      end
    for (int n = 0; n < 16; n++) sb[n] = dec_q ? INV_SBOX[sh[n]] : SBOX[sh[n]];
    for (int n = 0; n < 16; n++) ak[n] = sb[n] ^ rk_q[127-8*n -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        if (dec_q)
          mc[c*4+r] = gf_mul(ak[c*4+r], 8'd14) ^ gf_mul(ak[c*4+(r+1)%4], 8'd11)
                    ^ gf_mul(ak[c*4+(r+2)%4], 8'd13) ^ gf_mul(ak[c*4+(r+3)%4], 8'd9);
        else
          mc[c*4+r] = xtime(sb[c*4+r]) ^ xtime(sb[c*4+(r+1)%4]) ^ sb[c*4+(r+1)%4]
                    ^ sb[c*4+(r+2)%4] ^ sb[c*4+(r+3)%4];
      end
    for (int n = 0; n < 16; n++) begin
      if (last_q) nxt[127-8*n -: 8] = ak[n];
      else if (dec_q) nxt[127-8*n -: 8] = mc[n];
      else nxt[127-8*n -: 8] = mc[n] ^ rk_q[127-8*n -: 8];
    end
  end

  // block and op are captured when the word is accepted; core stays stable until load
  logic op_hold_q;
  always_ff @(posedge clk_i) begin
    if (load_q) st_q <= blk_q ^ rk_q;
    else if (round_q) st_q <= nxt;
    if (load_q) dec_q <= op_hold_q;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_start || (!cmd_i.exp_step && !cmd_i.load && !cmd_i.round && !load_q
        && !round_q)) begin
      blk_q     <= {in_i.block_high, in_i.block_low};
      op_hold_q <= in_i.operation;
    end
  end

  assign state_o = st_q;
endmodule

@@ sv/aes_block_cipher_top.sv @@
// Top level: APB register file, controller and datapath of the AES core.
// Usage:
//  Write key_length_mode (addr 0x00) and key words 0..3 (0x08..0x20, 64-bit
//  APB data) while the core is idle. Any such write marks round keys stale.
//  Raise start with the operation bit and the block while busy is low; the
//  word is taken at that edge. The first block after a key change first runs
//  the key expansion, one 32-bit key word per cycle, 44, 52 or 60 words in
//  all. The cipher then runs a load/key fetch step, Nr = 10, 12 or 14 rounds
//  and a final writeback step, and the result strobe rises with the written
//  back state. The strobe cycle is idle, and the next start can be taken at
//  the edge that ends it; a new block is not taken while one is in flight.
//  The registered round key memory read port sets the key fetch step.
//  result_valid_o is high for exactly one cycle with the result word; the
//  receiver cannot stall it. Reset clears the registers to zero, 128-bit
//  mode, and marks the keys stale; the round key memory is not cleared.
module aes_block_cipher_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [aes_pkg::AddrW-1:0] paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready,
  input  logic                 start,
  output logic                 busy,
  input  aes_pkg::aes_in_t     in_i,
  output logic                 result_valid_o,
  output aes_pkg::aes_out_t    result_o
);
  import aes_pkg::*;

  logic [1:0]  mode_q;
  logic [63:0] key_q [4];
  logic        stale_q;
  logic        wr;
  logic [2:0]  ridx;
  aes_cmd_t    cmd;
  aes_sts_t    sts;
  logic        done;
  logic [127:0] st;
  logic        done_q;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign ridx = paddr[AddrW-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      stale_q <= 1'b1;
    end else begin
      if (wr) begin
        case (ridx)
          RegMode: begin mode_q <= pwdata[1:0]; stale_q <= 1'b1; end
          RegKey0: begin key_q[0] <= pwdata; stale_q <= 1'b1; end
          RegKey1: begin key_q[1] <= pwdata; stale_q <= 1'b1; end
          RegKey2: begin key_q[2] <= pwdata; stale_q <= 1'b1; end
          RegKey3: begin key_q[3] <= pwdata; stale_q <= 1'b1; end
          default: ;
        endcase
      end else if (cmd.exp_start) begin
        stale_q <= 1'b0;
      end
    end
  end

  always_comb begin
    case (ridx)
      RegMode: prdata = {62'h0, mode_q};
      RegKey0: prdata = key_q[0];
      RegKey1: prdata = key_q[1];
      RegKey2: prdata = key_q[2];
      RegKey3: prdata = key_q[3];
      default: prdata = '0;
    endcase
  end

  aes_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i(start), .operation_i(in_i.operation), .stale_i(stale_q),
    .mode_i(mode_q), .sts_i(sts), .cmd_o(cmd), .busy_o(busy), .done_o(done)
  );

  aes_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_i, .mode_i(mode_q),
    .key_i({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .sts_o(sts), .state_o(st)
  );

  // last round writes the state at the edge that leaves StDone
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= done;
  end
  assign result_valid_o = done_q;
  assign result_o = st;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !$past(result_valid_o)) else $error("double strobe");
  a_stale_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exp_start |-> stale_q) else $error("expansion without stale keys");
  a_busy_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("start not taken");
endmodule
